@@ rtl/srosu_pkg.sv @@
`timescale 1ns / 1ps
package srosu_pkg;

    localparam int ZONE_W  = 4;
    localparam int POS_W   = 4;
    localparam int ACT_W   = 3;
    localparam int TIME_W  = 16;
    localparam int TOTAL_W = 20;

    localparam int MAX_ZONES_DEF = 8;
    localparam int ZONE_IDS_DEF  = 16;

    localparam logic [ACT_W-1:0] ACT_CLR_ROUTE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_ZONE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CLR_DIST  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LOAD_DIST = 3'd3;
    localparam logic [ACT_W-1:0] ACT_OPTIMIZE  = 3'd4;

    typedef struct packed {
        logic accept;
        logic prep_step;
        logic init;
        logic load;
        logic scan;
        logic cmp;
        logic next;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic opt_req;
        logic prep_done;
        logic scan_done;
        logic has_next;
        logic out_free;
        logic emit_last;
    } sts_t;

endpackage

@@ rtl/shortest_route_order_search_unit.sv @@
`timescale 1ns / 1ps
// Shortest route order search unit.
// Input channel (s_*): one beat is a command. Clear route, add zone, clear
// distances and load distance are accepted and produce no result beat.
// Optimize takes s_zone_a as the start zone and searches every order of the
// remaining route zones for the smallest open-path travel time.
// Result channel (m_*): one beat per zone of the best route, positions 0..n,
// m_is_last on the final zone, each beat carrying the route's total time.
// Optimize runs list setup (the start zone is taken out of the route list),
// then for each order of the remaining zones: a load step, one travel-time
// table read per path edge from the table RAM's single read port, a drain of
// the last read, then compare and next-order steps; then the result beats.
// s_ready is low for the whole optimize until the last result beat is loaded
// into the output register. A stalled receiver holds the result register and
// pauses the emission.
// Reset (aresetn low, synchronous) empties the route and marks every distance
// pair unloaded, so all pairs cost zero until loaded.
module shortest_route_order_search_unit #(
    parameter int MAX_ZONES = srosu_pkg::MAX_ZONES_DEF,
    parameter int ZONE_IDS  = srosu_pkg::ZONE_IDS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [srosu_pkg::ACT_W-1:0]       s_action,
    input  logic [srosu_pkg::ZONE_W-1:0]      s_zone_a,
    input  logic [srosu_pkg::ZONE_W-1:0]      s_zone_b,
    input  logic [srosu_pkg::TIME_W-1:0]      s_travel_time,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [srosu_pkg::ZONE_W-1:0]      m_zone_id,
    output logic [srosu_pkg::POS_W-1:0]       m_position,
    output logic                              m_is_last,
    output logic [srosu_pkg::TOTAL_W-1:0]     m_total_time
);

    srosu_pkg::cmd_t cmd;
    srosu_pkg::sts_t sts;

    srosu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    srosu_dp #(.MAX_ZONES(MAX_ZONES), .ZONE_IDS(ZONE_IDS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_action      (s_action),
        .s_zone_a      (s_zone_a),
        .s_zone_b      (s_zone_b),
        .s_travel_time (s_travel_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_zone_id     (m_zone_id),
        .m_position    (m_position),
        .m_is_last     (m_is_last),
        .m_total_time  (m_total_time)
    );

endmodule

@@ rtl/srosu_ram.sv @@
`timescale 1ns / 1ps
module srosu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/srosu_ctrl.sv @@
`timescale 1ns / 1ps
module srosu_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  srosu_pkg::sts_t  sts,
    output srosu_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_INIT = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_CMP  = 3'd5;
    localparam logic [2:0] ST_NEXT = 3'd6;
    localparam logic [2:0] ST_EMIT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid && sts.opt_req) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (sts.prep_done) begin
                    state_next = ST_INIT;
                end else begin
                    cmd.prep_step = 1'b1;
                end
            end
            ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = sts.has_next ? ST_NEXT : ST_EMIT;
            end
            ST_NEXT: begin
                cmd.next   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/srosu_dp.sv @@
`timescale 1ns / 1ps
module srosu_dp #(
    parameter int MAX_ZONES = srosu_pkg::MAX_ZONES_DEF,
    parameter int ZONE_IDS  = srosu_pkg::ZONE_IDS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  srosu_pkg::cmd_t                    cmd,
    output srosu_pkg::sts_t                    sts,
    input  logic [srosu_pkg::ACT_W-1:0]        s_action,
    input  logic [srosu_pkg::ZONE_W-1:0]       s_zone_a,
    input  logic [srosu_pkg::ZONE_W-1:0]       s_zone_b,
    input  logic [srosu_pkg::TIME_W-1:0]       s_travel_time,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [srosu_pkg::ZONE_W-1:0]       m_zone_id,
    output logic [srosu_pkg::POS_W-1:0]        m_position,
    output logic                               m_is_last,
    output logic [srosu_pkg::TOTAL_W-1:0]      m_total_time
);

    localparam int ORDER_LEN = MAX_ZONES + 1;
    localparam int TABLE_LEN = ZONE_IDS * ZONE_IDS;
    localparam int TW        = $clog2(TABLE_LEN);
    localparam int CNT_W     = $clog2(ORDER_LEN + 1);
    localparam int LIDX_W    = $clog2(ORDER_LEN);
    localparam int PW        = $clog2(MAX_ZONES);
    localparam int ZW        = srosu_pkg::ZONE_W;
    localparam int TOT_W     = srosu_pkg::TOTAL_W;
    localparam int TM_W      = srosu_pkg::TIME_W;

    function automatic logic [TW-1:0] pair_idx(input logic [ZW-1:0] x, input logic [ZW-1:0] y);
        logic [ZW-1:0] lo;
        logic [ZW-1:0] hi;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        return TW'(TW'(lo) * TW'(ZONE_IDS) + TW'(hi));
    endfunction

    function automatic logic in_range(input logic [ZW-1:0] z);
        return (32'(z) < ZONE_IDS);
    endfunction

    logic [ZW-1:0]    list_reg [ORDER_LEN];
    logic [CNT_W-1:0] count_reg;
    logic [ZW-1:0]    start_reg;
    logic [ZW-1:0]    pool_reg [MAX_ZONES];
    logic [CNT_W-1:0] plen_reg;
    logic [CNT_W-1:0] pi_reg;
    logic             removed_reg;
    logic [PW-1:0]    p_reg [MAX_ZONES];
    logic [ZW-1:0]    cur_reg [MAX_ZONES];
    logic [ZW-1:0]    sc_reg [ORDER_LEN];
    logic [CNT_W-1:0] rd_cnt_reg;
    logic             pend_reg;
    logic             ok_reg;
    logic [TOT_W-1:0] acc_reg;
    logic [TOT_W-1:0] best_total_reg;
    logic [ZW-1:0]    best_reg [ORDER_LEN];
    logic [CNT_W-1:0] e_reg;
    logic [TABLE_LEN-1:0] pw_reg;

    logic             m_valid_reg;
    logic [ZW-1:0]    m_zone_reg;
    logic [srosu_pkg::POS_W-1:0] m_pos_reg;
    logic             m_last_reg;
    logic [TOT_W-1:0] m_total_reg;

    logic [TW-1:0]    ld_idx;
    logic             ld_we;
    logic [TW-1:0]    rd_idx;
    logic             rd_ok;
    logic             issue;
    logic [TM_W-1:0]  rdata;
    logic [ZW-1:0]    list_ent;
    logic             add_ok;

    logic [PW-1:0]    pn [MAX_ZONES];
    logic [ZW-1:0]    cn [MAX_ZONES];
    logic             found;

    assign ld_idx = pair_idx(s_zone_a, s_zone_b);
    assign ld_we  = cmd.accept && (s_action == srosu_pkg::ACT_LOAD_DIST)
                    && in_range(s_zone_a) && in_range(s_zone_b) && !pw_reg[ld_idx];
    assign rd_idx = pair_idx(sc_reg[0], sc_reg[1]);
    assign rd_ok  = in_range(sc_reg[0]) && in_range(sc_reg[1]) && pw_reg[rd_idx];
    assign issue  = cmd.scan && (rd_cnt_reg != '0);
    assign list_ent = list_reg[pi_reg[LIDX_W-1:0]];
    assign add_ok = in_range(s_zone_a) && (count_reg < CNT_W'(MAX_ZONES));

    srosu_ram #(.WIDTH(TM_W), .DEPTH(TABLE_LEN)) u_table (
        .aclk  (aclk),
        .we    (ld_we),
        .waddr (ld_idx),
        .wdata (s_travel_time),
        .raddr (rd_idx),
        .rdata (rdata)
    );

    always_comb begin
        logic [PW-1:0]    i_idx;
        logic [PW-1:0]    j_idx;
        logic [PW-1:0]    psw [MAX_ZONES];
        logic [ZW-1:0]    csw [MAX_ZONES];
        logic [PW-1:0]    ptmp;
        logic [ZW-1:0]    ctmp;
        logic [CNT_W:0]   rev;
        found = 1'b0;
        i_idx = '0;
        for (int k = 0; k < MAX_ZONES - 1; k++) begin
            if (CNT_W'(k + 1) < plen_reg && p_reg[k] < p_reg[k+1]) begin
                found = 1'b1;
                i_idx = PW'(k);
            end
        end
        j_idx = '0;
        for (int k = 0; k < MAX_ZONES; k++) begin
            if (CNT_W'(k) < plen_reg && PW'(k) > i_idx && p_reg[k] > p_reg[i_idx]) begin
                j_idx = PW'(k);
            end
        end
        for (int k = 0; k < MAX_ZONES; k++) begin
            psw[k] = p_reg[k];
            csw[k] = cur_reg[k];
        end
        ptmp = psw[i_idx];
        ctmp = csw[i_idx];
        psw[i_idx] = psw[j_idx];
        csw[i_idx] = csw[j_idx];
        psw[j_idx] = ptmp;
        csw[j_idx] = ctmp;
        for (int k = 0; k < MAX_ZONES; k++) begin
            rev = (CNT_W+1)'(plen_reg) + (CNT_W+1)'(i_idx) - (CNT_W+1)'(k);
            if (PW'(k) > i_idx && CNT_W'(k) < plen_reg) begin
                pn[k] = psw[rev[PW-1:0]];
                cn[k] = csw[rev[PW-1:0]];
            end else begin
                pn[k] = psw[k];
                cn[k] = csw[k];
            end
        end
    end

    always_comb begin
        sts.opt_req   = (s_action == srosu_pkg::ACT_OPTIMIZE);
        sts.prep_done = (pi_reg == count_reg);
        sts.scan_done = (rd_cnt_reg == '0) && !pend_reg;
        sts.has_next  = found;
        sts.out_free  = !m_valid_reg || m_ready;
        sts.emit_last = (e_reg == plen_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pw_reg      <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                case (s_action)
                    srosu_pkg::ACT_CLR_ROUTE: count_reg <= '0;
                    srosu_pkg::ACT_ADD_ZONE: begin
                        if (add_ok) begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    srosu_pkg::ACT_CLR_DIST: pw_reg <= '0;
                    default: ;
                endcase
            end
            if (ld_we) begin
                pw_reg[ld_idx] <= 1'b1;
            end
            pend_reg <= issue;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
                if (sts.emit_last) begin
                    count_reg <= plen_reg + 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_action == srosu_pkg::ACT_ADD_ZONE && add_ok) begin
            list_reg[count_reg[LIDX_W-1:0]] <= s_zone_a;
        end
        if (cmd.accept) begin
            start_reg   <= s_zone_a;
            pi_reg      <= '0;
            plen_reg    <= '0;
            removed_reg <= 1'b0;
        end
        if (cmd.prep_step) begin
            pi_reg <= pi_reg + 1'b1;
            if (!removed_reg && list_ent == start_reg) begin
                removed_reg <= 1'b1;
            end else if (plen_reg < CNT_W'(MAX_ZONES)) begin
                pool_reg[plen_reg[PW-1:0]] <= list_ent;
                plen_reg <= plen_reg + 1'b1;
            end
        end
        if (cmd.init) begin
            for (int k = 0; k < MAX_ZONES; k++) begin
                p_reg[k]   <= PW'(k);
                cur_reg[k] <= pool_reg[k];
            end
            best_total_reg <= '1;
            e_reg          <= '0;
        end
        if (cmd.load) begin
            sc_reg[0] <= start_reg;
            for (int k = 0; k < MAX_ZONES; k++) begin
                sc_reg[k+1] <= cur_reg[k];
            end
            rd_cnt_reg <= plen_reg;
            acc_reg    <= '0;
        end
        if (issue) begin
            for (int k = 0; k < ORDER_LEN - 1; k++) begin
                sc_reg[k] <= sc_reg[k+1];
            end
            rd_cnt_reg <= rd_cnt_reg - 1'b1;
            ok_reg     <= rd_ok;
        end
        if (pend_reg && ok_reg) begin
            acc_reg <= acc_reg + TOT_W'(rdata);
        end
        if (cmd.cmp && acc_reg < best_total_reg) begin
            best_total_reg <= acc_reg;
            best_reg[0]    <= start_reg;
            for (int k = 0; k < MAX_ZONES; k++) begin
                best_reg[k+1] <= cur_reg[k];
            end
        end
        if (cmd.next) begin
            for (int k = 0; k < MAX_ZONES; k++) begin
                p_reg[k]   <= pn[k];
                cur_reg[k] <= cn[k];
            end
        end
        if (cmd.emit) begin
            list_reg[e_reg[LIDX_W-1:0]] <= best_reg[e_reg[LIDX_W-1:0]];
            m_zone_reg  <= best_reg[e_reg[LIDX_W-1:0]];
            m_pos_reg   <= srosu_pkg::POS_W'(e_reg);
            m_last_reg  <= sts.emit_last;
            m_total_reg <= best_total_reg;
            e_reg       <= e_reg + 1'b1;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_zone_id    = m_zone_reg;
    assign m_position   = m_pos_reg;
    assign m_is_last    = m_last_reg;
    assign m_total_time = m_total_reg;

endmodule

@@ bench/route_checker.sv @@
`timescale 1ns / 1ps
module route_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [srosu_pkg::ACT_W-1:0]    s_action,
    input  logic [srosu_pkg::ZONE_W-1:0]   s_zone_a,
    input  logic [srosu_pkg::ZONE_W-1:0]   s_zone_b,
    input  logic [srosu_pkg::TIME_W-1:0]   s_travel_time,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [srosu_pkg::ZONE_W-1:0]   m_zone_id,
    input  logic [srosu_pkg::POS_W-1:0]    m_position,
    input  logic                           m_is_last,
    input  logic [srosu_pkg::TOTAL_W-1:0]  m_total_time,
    output int                             fail_count,
    output int                             pending
);

    localparam int MAXZ = srosu_pkg::MAX_ZONES_DEF;
    localparam int NIDS = srosu_pkg::ZONE_IDS_DEF;

    typedef struct packed {
        logic [srosu_pkg::ZONE_W-1:0]  zone;
        logic [srosu_pkg::POS_W-1:0]   pos;
        logic                          last;
        logic [srosu_pkg::TOTAL_W-1:0] total;
    } route_beat_t;

    route_beat_t                   route_beats[$];
    logic [srosu_pkg::ZONE_W-1:0]  route_zones[MAXZ+1];
    int                            route_len;
    logic [srosu_pkg::TIME_W-1:0]  leg_time[NIDS*NIDS];
    logic                          leg_loaded[NIDS*NIDS];

    function automatic int leg_slot(input int x, input int y);
        return (x < y) ? x * NIDS + y : y * NIDS + x;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic void plan_route(input logic [srosu_pkg::ZONE_W-1:0] start);
        logic [srosu_pkg::ZONE_W-1:0]  pool[MAXZ+1];
        logic [srosu_pkg::ZONE_W-1:0]  best[MAXZ+1];
        int                            idx[MAXZ+1];
        int                            p, i, j, t, sum;
        logic [srosu_pkg::TOTAL_W-1:0] best_sum;
        bit                            taken, more;
        route_beat_t                   b;
        p = 0;
        taken = 0;
        for (i = 0; i < route_len; i++) begin
            if (!taken && route_zones[i] == start) begin
                taken = 1;
            end else if (p < MAXZ) begin
                pool[p] = route_zones[i];
                p++;
            end
        end
        for (i = 0; i < p; i++) idx[i] = i;
        best_sum = '1;
        more = 1;
        while (more) begin
            sum = 0;
            for (i = 0; i < p; i++)
                sum += leg_time[leg_slot(i == 0 ? start : pool[idx[i-1]], pool[idx[i]])];
            if (sum[srosu_pkg::TOTAL_W-1:0] < best_sum) begin
                best_sum = sum[srosu_pkg::TOTAL_W-1:0];
                best[0] = start;
                for (i = 0; i < p; i++) best[i+1] = pool[idx[i]];
            end
            i = p - 2;
            while (i >= 0 && idx[i] > idx[i+1]) i--;
            if (i < 0) begin
                more = 0;
            end else begin
                j = p - 1;
                while (idx[j] < idx[i]) j--;
                t = idx[i]; idx[i] = idx[j]; idx[j] = t;
                for (j = i + 1, t = p - 1; j < t; j++, t--) begin
                    sum = idx[j]; idx[j] = idx[t]; idx[t] = sum;
                end
            end
        end
        for (i = 0; i <= p; i++) begin
            route_zones[i] = best[i];
            b.zone  = best[i];
            b.pos   = i[srosu_pkg::POS_W-1:0];
            b.last  = (i == p);
            b.total = best_sum;
            route_beats = {route_beats, b};
        end
        route_len = p + 1;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
        route_len = 0;
        for (int k = 0; k < NIDS*NIDS; k++) begin
            leg_time[k] = '0;
            leg_loaded[k] = 0;
        end
    end

    always @(posedge aclk) begin
        route_beat_t want;
        if (!aresetn) begin
            route_len = 0;
            for (int k = 0; k < NIDS*NIDS; k++) begin
                leg_time[k] = '0;
                leg_loaded[k] = 0;
            end
        end else begin
            if (m_valid && m_ready) begin
                if (route_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat zone %0d pos %0d",
                                              m_zone_id, m_position));
                end else begin
                    want = route_beats.pop_front();
                    if (m_zone_id !== want.zone)
                        report_mismatch($sformatf("zone_id %0d, want %0d",
                                                  m_zone_id, want.zone));
                    if (m_position !== want.pos)
                        report_mismatch($sformatf("position %0d, want %0d",
                                                  m_position, want.pos));
                    if (m_is_last !== want.last)
                        report_mismatch($sformatf("is_last %0b, want %0b",
                                                  m_is_last, want.last));
                    if (m_total_time !== want.total)
                        report_mismatch($sformatf("total_time %0d, want %0d",
                                                  m_total_time, want.total));
                end
            end
            if (s_valid && s_ready) begin
                case (s_action)
                    srosu_pkg::ACT_CLR_ROUTE: route_len = 0;
                    srosu_pkg::ACT_ADD_ZONE: begin
                        if (route_len < MAXZ) begin
                            route_zones[route_len] = s_zone_a;
                            route_len++;
                        end
                    end
                    srosu_pkg::ACT_CLR_DIST: begin
                        for (int k = 0; k < NIDS*NIDS; k++) begin
                            leg_time[k] = '0;
                            leg_loaded[k] = 0;
                        end
                    end
                    srosu_pkg::ACT_LOAD_DIST: begin
                        if (!leg_loaded[leg_slot(s_zone_a, s_zone_b)]) begin
                            leg_time[leg_slot(s_zone_a, s_zone_b)] = s_travel_time;
                            leg_loaded[leg_slot(s_zone_a, s_zone_b)] = 1;
                        end
                    end
                    srosu_pkg::ACT_OPTIMIZE: plan_route(s_zone_a);
                    default: ;
                endcase
            end
        end
        pending = route_beats.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;

    localparam int STALL_LIMIT = 300000;

    logic                           aclk = 0;
    logic                           aresetn = 0;
    logic                           s_valid = 0;
    logic                           s_ready;
    logic [srosu_pkg::ACT_W-1:0]    s_action = '0;
    logic [srosu_pkg::ZONE_W-1:0]   s_zone_a = '0;
    logic [srosu_pkg::ZONE_W-1:0]   s_zone_b = '0;
    logic [srosu_pkg::TIME_W-1:0]   s_travel_time = '0;
    logic                           m_valid;
    logic                           m_ready = 0;
    logic [srosu_pkg::ZONE_W-1:0]   m_zone_id;
    logic [srosu_pkg::POS_W-1:0]    m_position;
    logic                           m_is_last;
    logic [srosu_pkg::TOTAL_W-1:0]  m_total_time;
    int                             fail_count;
    int                             pending;
    int                             sent;
    int                             list_size;
    int                             quiet;
    bit                             gaps_on = 1;
    bit                             hold_req = 0;
    int                             add_zones[9] = '{0, 15, 3, 5, 3, 7, 9, 1, 12};

    always #5 aclk = ~aclk;

    shortest_route_order_search_unit u_top (.*);

    route_checker u_chk (.*);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("FAIL shortest_route_order_search_unit");
                $finish;
            end
        end
    end

    initial begin
        bit held;
        int n;
        held = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                held = 1;
                m_ready = 0;
                repeat (400) @(negedge aclk);
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_ready = 0;
                n = $urandom_range(1, 4);
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready = 1;
            end
        end
    end

    task automatic send(input logic [srosu_pkg::ACT_W-1:0] act, input int za, input int zb,
                        input int tt);
        int n;
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid = 0;
            n = $urandom_range(1, 4);
            repeat (n) @(negedge aclk);
        end
        s_valid = 1;
        s_action = act;
        s_zone_a = za[srosu_pkg::ZONE_W-1:0];
        s_zone_b = zb[srosu_pkg::ZONE_W-1:0];
        s_travel_time = tt[srosu_pkg::TIME_W-1:0];
        do @(posedge aclk); while (!s_ready);
        sent++;
        case (act)
            srosu_pkg::ACT_CLR_ROUTE: list_size = 0;
            srosu_pkg::ACT_ADD_ZONE: if (list_size < srosu_pkg::MAX_ZONES_DEF) list_size++;
            srosu_pkg::ACT_OPTIMIZE: if (list_size < srosu_pkg::MAX_ZONES_DEF + 1) list_size++;
            default: ;
        endcase
    endtask

    initial begin
        int k, w, za;
        int zone_pick[$];
        sent = 0;
        list_size = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        send(srosu_pkg::ACT_OPTIMIZE, 15, 0, 0);
        send(3'd5, 3, 9, 16'h5555);
        send(3'd6, 15, 15, 16'hFFFF);
        send(3'd7, 0, 0, 0);
        send(srosu_pkg::ACT_LOAD_DIST, 3, 5, 16'hFFFF);
        send(srosu_pkg::ACT_LOAD_DIST, 5, 3, 1);
        send(srosu_pkg::ACT_LOAD_DIST, 0, 15, 0);
        send(srosu_pkg::ACT_LOAD_DIST, 7, 7, 123);
        send(srosu_pkg::ACT_CLR_DIST, 0, 0, 0);
        send(srosu_pkg::ACT_LOAD_DIST, 3, 5, 10);
        send(srosu_pkg::ACT_LOAD_DIST, 15, 0, 16'hFFFF);
        foreach (add_zones[i])
            send(srosu_pkg::ACT_ADD_ZONE, add_zones[i], 0, 0);
        send(srosu_pkg::ACT_OPTIMIZE, 3, 0, 0);
        send(srosu_pkg::ACT_CLR_ROUTE, 0, 0, 0);
        send(srosu_pkg::ACT_OPTIMIZE, 0, 0, 0);

        @(negedge aclk);
        s_valid = 0;
        while (pending != 0) @(negedge aclk);

        hold_req = 1;
        while (sent < 100) begin
            if (sent > 85) gaps_on = 0;
            if ($urandom_range(0, 9) < 7) begin
                k = $urandom_range(0, 4);
                if (list_size + k > 4 || $urandom_range(0, 2) == 0)
                    send(srosu_pkg::ACT_CLR_ROUTE, $urandom, $urandom, $urandom);
                if ($urandom_range(0, 3) == 0)
                    send(srosu_pkg::ACT_CLR_DIST, $urandom, $urandom, $urandom);
                zone_pick.delete();
                for (int i = 0; i < k; i++) begin
                    za = $urandom_range(0, 15);
                    zone_pick = {zone_pick, za};
                    send(srosu_pkg::ACT_ADD_ZONE, za, $urandom, $urandom);
                end
                w = $urandom_range(0, 5);
                for (int i = 0; i < w; i++) begin
                    if (zone_pick.size() > 1)
                        send(srosu_pkg::ACT_LOAD_DIST,
                             zone_pick[$urandom_range(0, zone_pick.size() - 1)],
                             zone_pick[$urandom_range(0, zone_pick.size() - 1)],
                             $urandom);
                    else
                        send(srosu_pkg::ACT_LOAD_DIST, $urandom, $urandom, $urandom);
                end
                if (zone_pick.size() > 0 && $urandom_range(0, 2) != 0)
                    za = zone_pick[$urandom_range(0, zone_pick.size() - 1)];
                else
                    za = $urandom_range(0, 15);
                if (list_size <= 5) send(srosu_pkg::ACT_OPTIMIZE, za, $urandom, $urandom);
            end else begin
                k = $urandom_range(0, 7);
                if (k == srosu_pkg::ACT_OPTIMIZE && list_size > 5) k = srosu_pkg::ACT_CLR_ROUTE;
                send(k[srosu_pkg::ACT_W-1:0], $urandom, $urandom, $urandom);
            end
        end

        @(negedge aclk);
        s_valid = 0;
        k = 0;
        while (pending != 0 && k < STALL_LIMIT) begin
            @(negedge aclk);
            k++;
        end
        repeat (50) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("PASS shortest_route_order_search_unit");
        else
            $display("FAIL shortest_route_order_search_unit");
        $finish;
    end

endmodule
